// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, character codes and helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // result status codes
  localparam logic [1:0] ST_UNIT  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  localparam logic [15:0] CH_QUOTE = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005c;
  localparam logic [15:0] CH_SLASH = 16'h002f;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB = 16'h0009;
  localparam logic [15:0] CH_CR = 16'h000d;
  localparam logic [15:0] CH_LF = 16'h000a;
  localparam logic [15:0] CH_LOW_B = 16'h0062;
  localparam logic [15:0] CH_LOW_F = 16'h0066;
  localparam logic [15:0] CH_LOW_N = 16'h006e;
  localparam logic [15:0] CH_LOW_R = 16'h0072;
  localparam logic [15:0] CH_LOW_T = 16'h0074;
  localparam logic [15:0] CH_LOW_U = 16'h0075;
  localparam logic [15:0] CH_BS = 16'h0008;
  localparam logic [15:0] CH_FF = 16'h000c;
  localparam logic [15:0] CTRL_LIMIT = 16'h0020;

  localparam logic [15:0] HIGH_SUR_LO = 16'hd800;
  localparam logic [15:0] HIGH_SUR_HI = 16'hdbff;
  localparam logic [15:0] LOW_SUR_LO = 16'hdc00;
  localparam logic [15:0] LOW_SUR_HI = 16'hdfff;

  // all results caused by one input unit, in order; cnt is 1 to 3
  typedef struct packed {
    logic [1:0]       cnt;
    logic [2:0][15:0] unit;
    logic [2:0][1:0]  st;
  } jsu_group_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } jsu_queue_status_t;

  // returns {ok, digit value}
  function automatic logic [4:0] hex_digit(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                 (c >= 16'h0041 && c <= 16'h0046)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- src/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front
// takes code units, tracks the string parse state and builds the result group
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [15:0]        code_unit,
  input  logic               text_ends,
  output logic               push,
  output jsu_pkg::jsu_group_t group
);

  typedef enum logic [6:0] {
    M_WS      = 7'b0000001,
    M_BODY    = 7'b0000010,
    M_ESC     = 7'b0000100,
    M_HEX     = 7'b0001000,
    M_WANT_BS = 7'b0010000,
    M_WANT_U  = 7'b0100000,
    M_HEX_LO  = 7'b1000000
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] high_half, high_half_next;

  always_comb begin
    logic [4:0]  hd;
    logic [15:0] acc_new;
    logic        done;
    logic [1:0]  nunits;
    logic [15:0] u0, u1;
    logic        close, err;

    hd = jsu_pkg::hex_digit(code_unit);
    acc_new = {hex_accum[11:0], hd[3:0]};
    done = hd[4] && (hex_seen == 2'd3);
    nunits = 2'd0;
    u0 = 16'd0;
    u1 = 16'd0;
    close = 1'b0;
    err = 1'b0;
    mode_next = mode;
    hex_seen_next = hex_seen;
    hex_accum_next = hex_accum;
    high_half_next = high_half;

    case (mode)
      M_BODY: begin
        if (code_unit == jsu_pkg::CH_QUOTE) begin
          close = 1'b1;
        end else if (code_unit < jsu_pkg::CTRL_LIMIT) begin
          err = 1'b1;
        end else if (code_unit == jsu_pkg::CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          nunits = 2'd1;
          u0 = code_unit;
        end
      end
      M_ESC: begin
        mode_next = M_BODY;
        nunits = 2'd1;
        case (code_unit)
          jsu_pkg::CH_QUOTE:  u0 = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BSLASH: u0 = jsu_pkg::CH_BSLASH;
          jsu_pkg::CH_SLASH:  u0 = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_LOW_B:  u0 = jsu_pkg::CH_BS;
          jsu_pkg::CH_LOW_F:  u0 = jsu_pkg::CH_FF;
          jsu_pkg::CH_LOW_N:  u0 = jsu_pkg::CH_LF;
          jsu_pkg::CH_LOW_R:  u0 = jsu_pkg::CH_CR;
          jsu_pkg::CH_LOW_T:  u0 = jsu_pkg::CH_TAB;
          jsu_pkg::CH_LOW_U: begin
            nunits = 2'd0;
            mode_next = M_HEX;
            hex_seen_next = 2'd0;
            hex_accum_next = 16'd0;
          end
          default: begin
            nunits = 2'd0;
            err = 1'b1;
          end
        endcase
      end
      M_HEX, M_HEX_LO: begin
        if (!hd[4]) begin
          err = 1'b1;
        end else if (!done) begin
          hex_accum_next = acc_new;
          hex_seen_next = hex_seen + 2'd1;
        end else if (mode == M_HEX) begin
          hex_seen_next = 2'd0;
          if (acc_new >= jsu_pkg::HIGH_SUR_LO && acc_new <= jsu_pkg::HIGH_SUR_HI) begin
            high_half_next = acc_new;
            hex_accum_next = 16'd0;
            mode_next = M_WANT_BS;
          end else if (acc_new >= jsu_pkg::LOW_SUR_LO && acc_new <= jsu_pkg::LOW_SUR_HI) begin
            err = 1'b1;
          end else begin
            nunits = 2'd1;
            u0 = acc_new;
            hex_accum_next = 16'd0;
            mode_next = M_BODY;
          end
        end else begin
          hex_seen_next = 2'd0;
          if (acc_new >= jsu_pkg::LOW_SUR_LO && acc_new <= jsu_pkg::LOW_SUR_HI) begin
            nunits = 2'd2;
            u0 = high_half;
            u1 = acc_new;
            hex_accum_next = 16'd0;
            high_half_next = 16'd0;
            mode_next = M_BODY;
          end else begin
            err = 1'b1;
          end
        end
      end
      M_WANT_BS: begin
        if (code_unit == jsu_pkg::CH_BSLASH) begin
          mode_next = M_WANT_U;
        end else begin
          err = 1'b1;
        end
      end
      M_WANT_U: begin
        if (code_unit == jsu_pkg::CH_LOW_U) begin
          mode_next = M_HEX_LO;
          hex_seen_next = 2'd0;
          hex_accum_next = 16'd0;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        // whitespace skipping, also any illegal state code
        if (code_unit == jsu_pkg::CH_SPACE || code_unit == jsu_pkg::CH_TAB ||
            code_unit == jsu_pkg::CH_CR || code_unit == jsu_pkg::CH_LF) begin
          mode_next = M_WS;
        end else if (code_unit == jsu_pkg::CH_QUOTE) begin
          mode_next = M_BODY;
          hex_seen_next = 2'd0;
          hex_accum_next = 16'd0;
          high_half_next = 16'd0;
        end else begin
          err = 1'b1;
        end
      end
    endcase

    group = '0;
    if (close || err) begin
      group.cnt = 2'd1;
      group.st[0] = close ? jsu_pkg::ST_CLOSE : jsu_pkg::ST_ERR;
    end else begin
      group.unit[0] = u0;
      group.unit[1] = u1;
      group.st[0] = jsu_pkg::ST_UNIT;
      group.st[1] = jsu_pkg::ST_UNIT;
      group.cnt = nunits;
      if (text_ends) begin
        // unterminated text: trailing error after any decoded units
        group.cnt = nunits + 2'd1;
        group.st[nunits] = jsu_pkg::ST_ERR;
        group.unit[nunits] = 16'd0;
      end
    end

    if (close || err || text_ends) begin
      mode_next = M_WS;
      hex_seen_next = 2'd0;
      hex_accum_next = 16'd0;
      high_half_next = 16'd0;
    end
  end

  assign push = accept && (group.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_WS;
      hex_seen <= 2'd0;
      hex_accum <= 16'd0;
      high_half <= 16'd0;
    end else if (accept) begin
      mode <= mode_next;
      hex_seen <= hex_seen_next;
      hex_accum <= hex_accum_next;
      high_half <= high_half_next;
    end
  end

  // an input that ends the text always leaves a closing or error result last
  a_ends_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && text_ends) |-> (push && group.st[group.cnt - 2'd1] != jsu_pkg::ST_UNIT))
    else $error("text end without terminating result");

  // the surrogate wait states only ever hold a high surrogate
  a_high_half: assert property (@(posedge clk) disable iff (rst)
    (mode == M_WANT_BS || mode == M_WANT_U || mode == M_HEX_LO) |->
      (high_half >= jsu_pkg::HIGH_SUR_LO && high_half <= jsu_pkg::HIGH_SUR_HI))
    else $error("surrogate wait without high surrogate");

endmodule

// ----- src/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue
// short queue of result groups between the front and back parts
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  jsu_pkg::jsu_group_t       wr_group,
  input  logic                      pop,
  output jsu_pkg::jsu_group_t       rd_group,
  output jsu_pkg::jsu_queue_status_t status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  jsu_pkg::jsu_group_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign status.full = (count == CW'(DEPTH));
  assign status.nonempty = (count != '0);
  assign rd_group = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !status.nonempty))
    else $error("pop from empty queue");

endmodule

// ----- src/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back
// walks each queued group and hands its results out one per cycle while out_stall is low
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic                       clk,
  input  logic                       rst,
  input  jsu_pkg::jsu_group_t        head,
  input  jsu_pkg::jsu_queue_status_t qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_unit,
  output logic [1:0]                 status,
  output logic                       run_end
);

  logic [1:0] idx;
  logic       load;
  logic       last;

  assign load = qstat.nonempty && (!out_valid || !out_stall);
  assign last = (idx == head.cnt - 2'd1);
  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= last ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_unit <= head.unit[idx];
      status <= head.st[idx];
      run_end <= last;
    end
  end

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != jsu_pkg::ST_UNIT) |-> (out_unit == 16'd0 && run_end))
    else $error("close or error result with payload or not last");

endmodule

// ----- src/json_string_unescape_unit.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// streaming json string decoder over utf-16 code units
// ----------------------------------------------------------------------------
// Input channel: code_unit/text_ends with in_valid/in_stall; one code unit is
// taken per cycle while in_stall is low. Output channel: out_unit/status/
// run_end with out_valid/out_stall; each input yields zero to three results,
// run_end marking the last one of an input.
// The front part decodes a unit in the cycle it is accepted and writes its
// results as one group into a small queue; the back part sends one result
// per cycle from the queue head through an output register while out_stall
// is low. Sustained rate is one unit per cycle while units give at most one
// result and out_stall is low; units that give two or three results send
// them one at a time through the single output register. in_stall rises
// when the queue is full, so a stalled receiver backs up the input after
// QUEUE_DEPTH groups plus the output register. Reset returns the parser to
// whitespace skipping and empties the queue and the output register.
// ----------------------------------------------------------------------------
module json_string_unescape_unit #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] code_unit,
  input  logic        text_ends,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_unit,
  output logic [1:0]  status,
  output logic        run_end
);

  jsu_pkg::jsu_group_t        front_group;
  jsu_pkg::jsu_group_t        head_group;
  jsu_pkg::jsu_queue_status_t qstat;
  logic                       accept;
  logic                       push;
  logic                       pop;

  assign in_stall = qstat.full;
  assign accept = in_valid && !in_stall;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_unit (code_unit),
    .text_ends (text_ends),
    .push      (push),
    .group     (front_group)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_group (front_group),
    .pop      (pop),
    .rd_group (head_group),
    .status   (qstat)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_group),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_unit  (out_unit),
    .status    (status),
    .run_end   (run_end)
  );

endmodule

// ----- verif/json_string_unescape_unit_tb.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_unit_tb
// Drives UTF-16 text into the json string unescaper. The text is whitespace,
// quoted strings with every escape form, surrogate pairs, malformed escapes,
// truncated text and raw noise. A decoder model inside the bench predicts
// every result, and each result from the block is compared with the oldest
// prediction. Both channels idle at random, and one stretch holds the output
// long enough to back up the input.
// ----------------------------------------------------------------------------
module json_string_unescape_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    SKIP_WS, IN_BODY, AFTER_BSLASH, HEX_DIGITS, WANT_BSLASH, WANT_U, LOW_HEX
  } scan_mode_t;

  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  st;
    logic        last;
  } dec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] code_unit = 16'h0000;
  logic        text_ends = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_unit;
  logic [1:0]  status;
  logic        run_end;

  // decoder model state
  scan_mode_t  scan_mode = SKIP_WS;
  logic [1:0]  hex_cnt = 2'd0;
  logic [15:0] hex_acc = 16'h0000;
  logic [15:0] high_sur = 16'h0000;

  dec_result_t expected_results[$];
  int          bad_count = 0;
  int          sent_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  json_string_unescape_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .code_unit (code_unit),
    .text_ends (text_ends),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_unit  (out_unit),
    .status    (status),
    .run_end   (run_end)
  );

  always #5 clk = ~clk;

  initial begin
    #4_000_000;
    $display("json_string_unescape_unit_tb failed");
    $finish;
  end

  function automatic int hex_val(input logic [15:0] c);
    if (c >= 16'h0030 && c <= 16'h0039) begin
      return int'(c) - 16'h0030;
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      return int'(c) - 16'h0061 + 10;
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      return int'(c) - 16'h0041 + 10;
    end
    return -1;
  endfunction

  function automatic void push_result(input logic [15:0] unit, input logic [1:0] st);
    dec_result_t r;
    r.unit = unit;
    r.st = st;
    r.last = 1'b0;
    expected_results = {expected_results, r};
  endfunction

  function automatic void add_unit(ref logic [15:0] txt[$], input logic [15:0] v);
    txt = {txt, v};
  endfunction

  function automatic void clear_scan();
    scan_mode = SKIP_WS;
    hex_cnt = 2'd0;
    hex_acc = 16'h0000;
    high_sur = 16'h0000;
  endfunction

  function automatic void decode_unit(input logic [15:0] c, input logic ends);
    int  first_idx;
    int  dig;
    bit  fin;
    bit  err;
    bit  done;
    first_idx = expected_results.size();
    fin = 1'b0;
    err = 1'b0;
    case (scan_mode)
      IN_BODY: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          push_result(16'h0000, jsu_pkg::ST_CLOSE);
          clear_scan();
          fin = 1'b1;
        end else if (c < jsu_pkg::CTRL_LIMIT) begin
          err = 1'b1;
        end else if (c == jsu_pkg::CH_BSLASH) begin
          scan_mode = AFTER_BSLASH;
        end else begin
          push_result(c, jsu_pkg::ST_UNIT);
        end
      end
      AFTER_BSLASH: begin
        scan_mode = IN_BODY;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
            push_result(c, jsu_pkg::ST_UNIT);
          jsu_pkg::CH_LOW_B: push_result(jsu_pkg::CH_BS, jsu_pkg::ST_UNIT);
          jsu_pkg::CH_LOW_F: push_result(jsu_pkg::CH_FF, jsu_pkg::ST_UNIT);
          jsu_pkg::CH_LOW_N: push_result(jsu_pkg::CH_LF, jsu_pkg::ST_UNIT);
          jsu_pkg::CH_LOW_R: push_result(jsu_pkg::CH_CR, jsu_pkg::ST_UNIT);
          jsu_pkg::CH_LOW_T: push_result(jsu_pkg::CH_TAB, jsu_pkg::ST_UNIT);
          jsu_pkg::CH_LOW_U: begin
            scan_mode = HEX_DIGITS;
            hex_cnt = 2'd0;
            hex_acc = 16'h0000;
          end
          default: err = 1'b1;
        endcase
      end
      HEX_DIGITS, LOW_HEX: begin
        dig = hex_val(c);
        if (dig < 0) begin
          err = 1'b1;
        end else begin
          hex_acc = {hex_acc[11:0], 4'(dig)};
          done = (hex_cnt == 2'd3);
          hex_cnt = hex_cnt + 2'd1;
          if (done && scan_mode == HEX_DIGITS) begin
            if (hex_acc >= jsu_pkg::HIGH_SUR_LO && hex_acc <= jsu_pkg::HIGH_SUR_HI) begin
              high_sur = hex_acc;
              hex_acc = 16'h0000;
              scan_mode = WANT_BSLASH;
            end else if (hex_acc >= jsu_pkg::LOW_SUR_LO &&
                         hex_acc <= jsu_pkg::LOW_SUR_HI) begin
              err = 1'b1;
            end else begin
              push_result(hex_acc, jsu_pkg::ST_UNIT);
              hex_acc = 16'h0000;
              scan_mode = IN_BODY;
            end
          end else if (done) begin
            if (hex_acc >= jsu_pkg::LOW_SUR_LO && hex_acc <= jsu_pkg::LOW_SUR_HI) begin
              push_result(high_sur, jsu_pkg::ST_UNIT);
              push_result(hex_acc, jsu_pkg::ST_UNIT);
              hex_acc = 16'h0000;
              high_sur = 16'h0000;
              scan_mode = IN_BODY;
            end else begin
              err = 1'b1;
            end
          end
        end
      end
      WANT_BSLASH: begin
        if (c == jsu_pkg::CH_BSLASH) scan_mode = WANT_U;
        else err = 1'b1;
      end
      WANT_U: begin
        if (c == jsu_pkg::CH_LOW_U) begin
          scan_mode = LOW_HEX;
          hex_cnt = 2'd0;
          hex_acc = 16'h0000;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        if (c == jsu_pkg::CH_SPACE || c == jsu_pkg::CH_TAB ||
            c == jsu_pkg::CH_CR || c == jsu_pkg::CH_LF) begin
          scan_mode = SKIP_WS;
        end else if (c == jsu_pkg::CH_QUOTE) begin
          clear_scan();
          scan_mode = IN_BODY;
        end else begin
          err = 1'b1;
        end
      end
    endcase
    if (err) begin
      push_result(16'h0000, jsu_pkg::ST_ERR);
      clear_scan();
      fin = 1'b1;
    end
    // truncated text closes with an error unless this unit already finished
    if (ends && !fin) begin
      push_result(16'h0000, jsu_pkg::ST_ERR);
      clear_scan();
    end
    if (expected_results.size() > first_idx)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_result();
    dec_result_t want;
    if (expected_results.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("unexpected result: unit=%h status=%0d run_end=%b",
                 out_unit, status, run_end);
    end else begin
      want = expected_results.pop_front();
      if (out_unit !== want.unit || status !== want.st || run_end !== want.last) begin
        bad_count++;
        if (bad_count <= 10)
          $display("mismatch: want unit=%h st=%0d end=%b, got unit=%h st=%0d end=%b",
                   want.unit, want.st, want.last, out_unit, status, run_end);
      end
    end
  endfunction

  // output side: checks each transaction and drives out_stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send_unit(input logic [15:0] cu, input logic te);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    code_unit <= cu;
    text_ends <= te;
    decode_unit(cu, te);
    sent_count++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input logic [15:0] txt[$], input bit ends_last);
    foreach (txt[i]) send_unit(txt[i], ends_last && i == txt.size() - 1);
  endtask

  task automatic send_ascii(input string s, input bit ends_last);
    for (int i = 0; i < s.len(); i++)
      send_unit({8'h00, s[i]}, ends_last && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 16'h0030 + 16'(nib);
    if ($urandom_range(0, 1)) return 16'h0061 + 16'(nib) - 16'd10;
    return 16'h0041 + 16'(nib) - 16'd10;
  endfunction

  function automatic void push_u_escape(ref logic [15:0] txt[$], input logic [15:0] v);
    add_unit(txt, jsu_pkg::CH_BSLASH);
    add_unit(txt, jsu_pkg::CH_LOW_U);
    for (int i = 3; i >= 0; i--) add_unit(txt, hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] ws_char();
    case ($urandom_range(0, 3))
      0: return jsu_pkg::CH_SPACE;
      1: return jsu_pkg::CH_TAB;
      2: return jsu_pkg::CH_CR;
      default: return jsu_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [15:0] plain_char(input bit ascii_only);
    logic [15:0] v;
    v = ascii_only ? 16'($urandom_range(16'h20, 16'h7e))
                   : 16'($urandom_range(16'h20, 16'hffff));
    if (v == jsu_pkg::CH_QUOTE || v == jsu_pkg::CH_BSLASH) v = 16'h0041;
    return v;
  endfunction

  task automatic test_leading_whitespace();
    send_ascii(" \t\r\n\"a\"", 1'b0);
    send_unit(16'h0078, 1'b0);       // junk before the quote
    send_unit(16'hffff, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(jsu_pkg::CH_SPACE, 1'b1);  // text ends while skipping
  endtask

  task automatic test_simple_escapes();
    send_ascii("\"\\\"\\\\\\/\\b\\f\\n\\r\\t", 1'b0);
    send_unit(16'hffff, 1'b0);
    send_unit(jsu_pkg::CH_QUOTE, 1'b1);  // close on the final unit gives no error
  endtask

  task automatic test_unicode_escapes();
    send_ascii("\"\\u0041\\uFfFf\\u0000\\uD83D\\uDE00\\udbff\\udfff\\uD800\\uDC00\"", 1'b0);
  endtask

  task automatic test_malformed_input();
    send_ascii("\"", 1'b0);
    send_unit(16'h001f, 1'b0);       // raw control unit
    send_ascii("\"\\x", 1'b0);       // unknown escape
    send_ascii("\"\\u12g", 1'b0);    // bad hex digit
    send_ascii("\"\\uDC00", 1'b0);   // lone low half
    send_ascii("\"\\uD800a", 1'b0);  // high half with no backslash after
    send_ascii("\"\\uD800\\x", 1'b0);
    send_ascii("\"\\uD800\\u0041", 1'b0);
    send_ascii("\"\\uD800\\uDC0z", 1'b0);
    send_ascii("\"ab", 1'b1);        // text ends inside the body
    send_ascii("\"\\", 1'b1);
    send_ascii("\"\\u00", 1'b1);
    send_ascii("\"\\q", 1'b1);       // error and end on the same unit
  endtask

  task automatic random_string();
    logic [15:0] txt[$];
    logic [15:0] esc_letters[8];
    int fault;
    int cut;
    esc_letters = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                    jsu_pkg::CH_LOW_B, jsu_pkg::CH_LOW_F, jsu_pkg::CH_LOW_N,
                    jsu_pkg::CH_LOW_R, jsu_pkg::CH_LOW_T};
    repeat ($urandom_range(0, 2)) add_unit(txt, ws_char());
    add_unit(txt, jsu_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_unit(txt, plain_char(1'b1));
        3: add_unit(txt, plain_char(1'b0));
        4, 5: begin
          add_unit(txt, jsu_pkg::CH_BSLASH);
          add_unit(txt, esc_letters[$urandom_range(0, 7)]);
        end
        6, 7: push_u_escape(txt, 16'($urandom_range(0, 16'hd7ff)));
        8: begin
          push_u_escape(txt, 16'($urandom_range(jsu_pkg::HIGH_SUR_LO, jsu_pkg::HIGH_SUR_HI)));
          push_u_escape(txt, 16'($urandom_range(jsu_pkg::LOW_SUR_LO, jsu_pkg::LOW_SUR_HI)));
        end
        default: push_u_escape(txt, 16'($urandom()));
      endcase
    end
    add_unit(txt, jsu_pkg::CH_QUOTE);
    fault = $urandom_range(0, 11);
    if (fault == 0) begin
      txt[$urandom_range(0, txt.size() - 1)] = 16'($urandom());
    end else if (fault == 1) begin
      cut = $urandom_range(1, txt.size());
      while (txt.size() > cut) void'(txt.pop_back());
    end
    send_text(txt, fault == 1 || fault == 2);
  endtask

  task automatic random_noise();
    logic [15:0] v;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: v = 16'($urandom());
        1: v = ws_char();
        2: v = jsu_pkg::CH_QUOTE;
        default: v = 16'($urandom_range(0, 16'h1f));
      endcase
      send_unit(v, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_random_strings(input int n_items);
    int stop;
    stop = sent_count + n_items;
    while (sent_count < stop) begin
      if ($urandom_range(0, 9) == 0) random_noise();
      else random_string();
    end
  endtask

  // output held for a long stretch while text keeps coming, then a full drain
  task automatic test_output_backpressure();
    hold_req++;
    repeat (6) random_string();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 80;
    test_leading_whitespace();
    test_simple_escapes();
    test_unicode_escapes();
    test_malformed_input();

    send_idle_pct = 80;
    recv_idle_pct = 16;
    test_random_strings(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_strings(70);

    wait_drained();
    repeat (20) @(posedge clk);
    if (bad_count == 0 && expected_results.size() == 0) begin
      $display("json_string_unescape_unit_tb passed");
    end else begin
      $display("json_string_unescape_unit_tb failed");
    end
    $finish;
  end

endmodule

// ----- json_string_unescape_unit.f -----
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_unit.sv
verif/json_string_unescape_unit_tb.sv
